// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. Each macro expects aclk and
// aresetn in scope and stays silent while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define SKL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SKL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/skl_pkg.sv =====
// ---------------------------------------------------------------------------
// skl_pkg
// Item types, operation codes and status codes of the sorted key list.
// ---------------------------------------------------------------------------
package skl_pkg;

    localparam int unsigned PidBits   = 16;
    localparam int unsigned CountBits = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic               operation;
        logic [PidBits-1:0] process_id;
    } req_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [CountBits-1:0] entry_count;
    } rsp_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic update;
        logic remove;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/skl_cell.sv =====
// ---------------------------------------------------------------------------
// skl_cell
// One slot of the sorted chain: holds a key, compares it with the request
// key and takes its own, the new or a neighbour's key on an update.
// ---------------------------------------------------------------------------
module skl_cell #(
    parameter int unsigned KEY_BITS = 16
) (
    input  logic                aclk,
    input  skl_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic [KEY_BITS-1:0] key_in,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic                left_below,
    input  logic [KEY_BITS-1:0] right_key,
    output logic [KEY_BITS-1:0] key,
    output logic                below,
    output logic                match
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;

    always_comb begin
        below = occupied && (key_reg < key_in);
        match = occupied && (key_reg == key_in);
    end

    always_comb begin
        key_next = key_reg;
        if (!below) begin
            if (ctrl.remove) begin
                // close the gap: pull the larger key down
                key_next = right_key;
            end else if (left_below) begin
                key_next = key_in;
            end else begin
                key_next = left_key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.update) begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

// ===== rtl/core/sorted_key_list.sv =====
// ---------------------------------------------------------------------------
// sorted_key_list
// Bounded store of distinct keys kept in ascending order, with insert and
// remove requests and one status item returned per request.
// ---------------------------------------------------------------------------
// The block takes one request item per clock cycle while s_ready is high.
// Every cell of the chain compares its key with the request key in the
// cycle of acceptance, and the chain shifts up or down by one cell at that
// same edge, so each request is settled there and the next item may follow
// at once. The result item appears on the m_ channel in the cycle after
// acceptance and sits in an output register; a new request is taken while
// that register is empty or is being emptied. Keys wider than the request
// field are zero extended; narrower ones use the low KEY_BITS bits of
// process_id. No clearing pass is needed after reset.
module sorted_key_list #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned KEY_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  skl_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output skl_pkg::rsp_t m_data
);

`include "assert_macros.svh"

    localparam int unsigned CntBits  = $clog2(CAPACITY + 1);
    localparam int unsigned UsedBits =
        (KEY_BITS < skl_pkg::PidBits) ? KEY_BITS : skl_pkg::PidBits;

    logic [CntBits-1:0]  count_reg;
    logic [CntBits-1:0]  count_next;
    logic                m_valid_reg;
    skl_pkg::rsp_t       m_data_reg;
    skl_pkg::rsp_t       rsp_next;

    logic                accept;
    logic                out_load;
    logic                is_remove;
    logic                found;
    logic                full;
    logic [KEY_BITS-1:0] key_in;
    skl_pkg::cell_ctrl_t ctrl;

    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0] below;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] occupied;

    assign key_in    = KEY_BITS'(s_data.process_id[UsedBits-1:0]);
    assign is_remove = (s_data.operation == skl_pkg::OP_REMOVE);
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign out_load  = accept;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic [KEY_BITS-1:0] left_key;
            logic                left_below;
            logic [KEY_BITS-1:0] right_key;

            assign occupied[i] = (CntBits'(i) < count_reg);

            if (i == 0) begin : g_first
                assign left_key   = key_in;
                assign left_below = 1'b1;
            end else begin : g_inner
                assign left_key   = cell_key[i-1];
                assign left_below = below[i-1];
            end

            if (i == CAPACITY - 1) begin : g_last
                assign right_key = cell_key[i];
            end else begin : g_body
                assign right_key = cell_key[i+1];
            end

            skl_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occupied   (occupied[i]),
                .key_in     (key_in),
                .left_key   (left_key),
                .left_below (left_below),
                .right_key  (right_key),
                .key        (cell_key[i]),
                .below      (below[i]),
                .match      (match[i])
            );
        end
    endgenerate

    assign found = |match;
    assign full  = (count_reg == CntBits'(CAPACITY));

    always_comb begin
        ctrl.remove = is_remove;
        ctrl.update = 1'b0;
        count_next  = count_reg;
        rsp_next.status = skl_pkg::ST_ADDED;
        if (is_remove) begin
            if (found) begin
                rsp_next.status = skl_pkg::ST_REMOVED;
                ctrl.update     = accept;
                count_next      = count_reg - CntBits'(1);
            end else begin
                rsp_next.status = skl_pkg::ST_NOTFOUND;
            end
        end else begin
            // duplicate check wins over full
            if (found) begin
                rsp_next.status = skl_pkg::ST_DUPLICATE;
            end else if (full) begin
                rsp_next.status = skl_pkg::ST_FULL;
            end else begin
                ctrl.update = accept;
                count_next  = count_reg + CntBits'(1);
            end
        end
        rsp_next.entry_count = skl_pkg::CountBits'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SKL_ASSERT_ALWAYS(a_count_bound, count_reg <= CntBits'(CAPACITY), "count exceeds capacity")
    `SKL_ASSERT_NEXT(a_rsp_count, out_load, m_data.entry_count == skl_pkg::CountBits'(count_reg), "reported count differs from stored count")
    `SKL_ASSERT_NEXT(a_insert_grows, ctrl.update && !ctrl.remove, count_reg == $past(count_reg) + CntBits'(1), "insert did not grow the store")
    `SKL_ASSERT_NEXT(a_refused_holds, accept && !ctrl.update, count_reg == $past(count_reg), "refused request changed the count")

endmodule
